### design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define B58_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define B58_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/b58_pkg.sv
`timescale 1ns / 1ps
// shared constants, word types and the digit lookup for the base58 decoder
// no dependencies
package b58_pkg;

    localparam int MAX_OUT_BYTES = 32;
    localparam int LEN_W         = $clog2(MAX_OUT_BYTES + 1);
    localparam int IDX_W         = (MAX_OUT_BYTES > 1) ? $clog2(MAX_OUT_BYTES) : 1;
    localparam int SUM_W         = LEN_W + 1;
    localparam int BYTE_W        = 8;
    localparam int CARRY_W       = 6;
    localparam int PROD_W        = BYTE_W + CARRY_W;

    localparam logic [CARRY_W-1:0] DIGIT_INVALID = CARRY_W'(58);
    localparam logic [CARRY_W-1:0] DIGIT_ZERO    = '0;
    localparam logic [PROD_W-1:0]  RADIX         = PROD_W'(58);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic ALPHA_PLAIN   = 1'b0;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       final_byte;
        logic [1:0] status;
    } out_word_t;

    // carry wave passed from one cell to the next
    typedef struct packed {
        logic               go;
        logic [CARRY_W-1:0] carry;
    } b58_wave_t;

    function automatic logic [CARRY_W-1:0] digit_of(input logic [7:0] ch, input logic sel);
        logic [7:0] d;
        d = 8'(DIGIT_INVALID);
        if (ch >= "1" && ch <= "9")
        begin
            d = 8'(ch - "1");
        end
        else if (sel == ALPHA_PLAIN)
        begin
            if (ch >= "A" && ch <= "H")      d = 8'(ch - "A" + 8'd9);
            else if (ch >= "J" && ch <= "N") d = 8'(ch - "J" + 8'd17);
            else if (ch >= "P" && ch <= "Z") d = 8'(ch - "P" + 8'd22);
            else if (ch >= "a" && ch <= "k") d = 8'(ch - "a" + 8'd33);
            else if (ch >= "m" && ch <= "z") d = 8'(ch - "m" + 8'd44);
        end
        else
        begin
            if (ch >= "a" && ch <= "k")      d = 8'(ch - "a" + 8'd9);
            else if (ch >= "m" && ch <= "z") d = 8'(ch - "m" + 8'd20);
            else if (ch >= "A" && ch <= "H") d = 8'(ch - "A" + 8'd34);
            else if (ch >= "J" && ch <= "N") d = 8'(ch - "J" + 8'd42);
            else if (ch >= "P" && ch <= "Z") d = 8'(ch - "P" + 8'd47);
        end
        return d[CARRY_W-1:0];
    endfunction

endpackage

### design/base58_text_decoder.sv
`timescale 1ns / 1ps
// base58 string decoder top level: input capture, control sequencer, output register
// depends on b58_pkg and b58_chain
//
// channel  | valid      | stall      | word
// ---------+------------+------------+------------------------------------
// input    | char_valid | char_stall | char_word  (text_char, end_of_string)
// output   | byte_valid | byte_stall | byte_word  (out_byte, final_byte, status)
// config   | cfg_we     | none       | cfg_data   (alphabet_select)
//
// a leading '1' or a discarded character is handled in ST_CHECK, an invalid
// character goes on to ST_ERROR; any other digit starts a carry wave crossing
// one byte cell per cycle through up to 32 stored bytes, ST_ERROR on overflow
// after the marked character the bytes leave one per cycle unless stalled, most
// significant first; reset clears all control state at once, no clearing pass
// output stall holds the result register; a new character is taken only when idle
module base58_text_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               char_valid,
    output logic               char_stall,
    input  b58_pkg::in_word_t  char_word,
    output logic               byte_valid,
    input  logic               byte_stall,
    output b58_pkg::out_word_t byte_word
);
    import b58_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_ERROR = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic               alpha_reg, alpha_next;
    in_word_t           char_reg, char_next;
    logic [CARRY_W-1:0] digit_reg, digit_next;
    logic               start_reg, start_next;
    logic [LEN_W-1:0]   walk_reg, walk_next;
    logic [LEN_W-1:0]   used_reg, used_next;
    logic [LEN_W-1:0]   zero_reg, zero_next;
    logic               leading_reg, leading_next;
    logic               discard_reg, discard_next;
    logic [1:0]         err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic [CARRY_W-1:0] digit;
    logic [CARRY_W-1:0] end_carry;
    logic [7:0]         rd_byte;
    logic [IDX_W-1:0]   rd_idx;
    logic [SUM_W-1:0]   total;
    logic               out_free;

    assign digit    = digit_of(char_reg.text_char, alpha_reg);
    assign rd_idx   = IDX_W'(used_reg - LEN_W'(1));
    assign total    = SUM_W'(zero_reg) + SUM_W'(used_reg);
    assign out_free = !out_valid_reg || !byte_stall;

    b58_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .digit     (digit_reg),
        .used_len  (used_reg),
        .rd_idx    (rd_idx),
        .end_carry (end_carry),
        .rd_byte   (rd_byte)
    );

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = cfg_we ? cfg_data : alpha_reg;
        char_next      = char_reg;
        digit_next     = digit_reg;
        start_next     = 1'b0;
        walk_next      = walk_reg;
        used_next      = used_reg;
        zero_next      = zero_reg;
        leading_next   = leading_reg;
        discard_next   = discard_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && byte_stall;
        out_word_next  = out_word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (char_valid)
                begin
                    char_next  = char_word;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (discard_reg)
                begin
                    if (char_reg.end_of_string)
                    begin
                        used_next    = '0;
                        zero_next    = '0;
                        leading_next = 1'b1;
                        discard_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
                else if (digit == DIGIT_INVALID)
                begin
                    err_next   = STATUS_BAD_CHAR;
                    state_next = ST_ERROR;
                end
                else if (leading_reg && digit == DIGIT_ZERO)
                begin
                    if (zero_reg >= LEN_W'(MAX_OUT_BYTES))
                    begin
                        err_next   = STATUS_OVERFLOW;
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        zero_next  = zero_reg + LEN_W'(1);
                        state_next = char_reg.end_of_string ? ST_EMIT : ST_IDLE;
                    end
                end
                else
                begin
                    leading_next = 1'b0;
                    start_next   = 1'b1;
                    digit_next   = digit;
                    walk_next    = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_reg == used_reg)
                begin
                    if (end_carry != '0 && total + SUM_W'(1) > SUM_W'(MAX_OUT_BYTES))
                    begin
                        err_next   = STATUS_OVERFLOW;
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        if (end_carry != '0)
                        begin
                            used_next = used_reg + LEN_W'(1);
                        end
                        state_next = char_reg.end_of_string ? ST_EMIT : ST_IDLE;
                    end
                end
                else
                begin
                    walk_next = walk_reg + LEN_W'(1);
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.out_byte   = '0;
                    out_word_next.final_byte = 1'b1;
                    out_word_next.status     = err_reg;
                    if (char_reg.end_of_string)
                    begin
                        used_next    = '0;
                        zero_next    = '0;
                        leading_next = 1'b1;
                        discard_next = 1'b0;
                    end
                    else
                    begin
                        discard_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.status     = STATUS_OK;
                    out_word_next.final_byte = (total == SUM_W'(1));
                    if (zero_reg != '0)
                    begin
                        out_word_next.out_byte = '0;
                        zero_next              = zero_reg - LEN_W'(1);
                    end
                    else
                    begin
                        out_word_next.out_byte = rd_byte;
                        used_next              = used_reg - LEN_W'(1);
                    end
                    if (total == SUM_W'(1))
                    begin
                        leading_next = 1'b1;
                        discard_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= ALPHA_PLAIN;
            start_reg     <= 1'b0;
            walk_reg      <= '0;
            used_reg      <= '0;
            zero_reg      <= '0;
            leading_reg   <= 1'b1;
            discard_reg   <= 1'b0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            start_reg     <= start_next;
            walk_reg      <= walk_next;
            used_reg      <= used_next;
            zero_reg      <= zero_next;
            leading_reg   <= leading_next;
            discard_reg   <= discard_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        digit_reg    <= digit_next;
        out_word_reg <= out_word_next;
    end

    assign char_stall = (state_reg != ST_IDLE);
    assign byte_valid = out_valid_reg;
    assign byte_word  = out_word_reg;

endmodule

### design/b58_cell.sv
`timescale 1ns / 1ps
// one byte of the little-endian number: multiply by 58, add carry, pass carry on
// depends on b58_pkg
module b58_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  b58_pkg::b58_wave_t wave_in,
    input  logic              in_use,
    output b58_pkg::b58_wave_t wave_out,
    output logic [7:0]        byte_val
);
    import b58_pkg::*;

    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               go_reg, go_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [PROD_W-1:0]  prod;

    assign prod = PROD_W'(byte_reg) * RADIX + PROD_W'(wave_in.carry);

    always_comb
    begin
        byte_next  = byte_reg;
        carry_next = carry_reg;
        go_next    = wave_in.go & in_use;
        if (wave_in.go)
        begin
            if (in_use)
            begin
                byte_next  = prod[BYTE_W-1:0];
                carry_next = prod[PROD_W-1:BYTE_W];
            end
            else
            begin
                // append position
                byte_next = BYTE_W'(wave_in.carry);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        carry_reg <= carry_next;
    end

    assign wave_out = '{go: go_reg, carry: carry_reg};
    assign byte_val = byte_reg;

endmodule

### design/b58_chain.sv
`timescale 1ns / 1ps
// row of byte cells with the carry wave running from cell 0 upward
// depends on b58_pkg and b58_cell
module b58_chain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [b58_pkg::CARRY_W-1:0] digit,
    input  logic [b58_pkg::LEN_W-1:0]   used_len,
    input  logic [b58_pkg::IDX_W-1:0]   rd_idx,
    output logic [b58_pkg::CARRY_W-1:0] end_carry,
    output logic [7:0]                  rd_byte
);
    import b58_pkg::*;

    b58_wave_t   wave [MAX_OUT_BYTES+1];
    logic [7:0]  bytes [MAX_OUT_BYTES];

    assign wave[0] = '{go: start, carry: digit};

    for (genvar j = 0; j < MAX_OUT_BYTES; j++)
    begin : g_cell
        logic in_use;
        assign in_use = (LEN_W'(j) < used_len);

        b58_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wave_in  (wave[j]),
            .in_use   (in_use),
            .wave_out (wave[j+1]),
            .byte_val (bytes[j])
        );
    end

    // carry arriving at the first unused cell
    assign end_carry = wave[used_len].carry;
    assign rd_byte   = bytes[rd_idx];

endmodule

### design/b58_checker.sv
`timescale 1ns / 1ps
// port-level checks for the base58 decoder, bound to the top level
// depends on b58_pkg and assert_macros.svh
`include "assert_macros.svh"

module b58_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               char_valid,
    input logic               char_stall,
    input logic               byte_valid,
    input logic               byte_stall,
    input b58_pkg::out_word_t byte_word
);
    import b58_pkg::*;

    `B58_ASSERT_NEXT(a_out_hold, clk, rst_n, byte_valid && byte_stall, byte_valid, "result dropped while stalled")
    `B58_ASSERT_NEXT(a_out_stable, clk, rst_n, byte_valid && byte_stall, $stable(byte_word), "stalled result changed")
    `B58_ASSERT(a_err_word, clk, rst_n, byte_valid && byte_word.status != STATUS_OK |-> byte_word.final_byte && byte_word.out_byte == '0, "error result not final or not zero")
    `B58_ASSERT_NEXT(a_one_char, clk, rst_n, char_valid && !char_stall, char_stall, "second character taken while busy")

endmodule

bind base58_text_decoder b58_checker u_b58_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for base58_text_decoder: queued character words, random gaps and stalls,
// predicted byte words checked field by field; depends on b58_pkg and the decoder rtl
module tb_top;
    import b58_pkg::*;

    localparam logic ALPHA_SWAPPED = 1'b1;
    localparam int   STALL_LIMIT   = 5000;
    localparam int   DRAIN_CYCLES  = 40;
    localparam int   MAX_PRINTS    = 50;

    localparam logic [8*58-1:0] PLAIN_DIGITS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam logic [8*58-1:0] SWAPPED_DIGITS =
        "123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic       cfg_data   = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_stall;
    in_word_t   char_word  = '0;
    logic       byte_valid;
    logic       byte_stall = 1'b0;
    out_word_t  byte_word;

    in_word_t   pending_chars[$];
    out_word_t  expected_bytes[$];
    out_word_t  want_word;

    // predictor state
    logic [7:0] store_bytes[0:MAX_OUT_BYTES-1];
    int         store_len;
    int         lead_zeros;
    logic       in_lead;
    logic       dropping;
    logic       alpha_sel;

    int send_gap_pct;
    int recv_gap_pct;
    int mismatch_count;
    int chars_in;
    int bytes_out;
    int error_words;
    int quiet_cycles;

    base58_text_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word)
    );

    always #2 clk = ~clk;

    function automatic int digit_value(input logic [7:0] ch, input logic sel);
        logic [8*58-1:0] tab;
        int i;
        tab = (sel == ALPHA_PLAIN) ? PLAIN_DIGITS : SWAPPED_DIGITS;
        for (i = 0; i < 58; i++)
        begin
            if (tab[8*(57-i) +: 8] == ch)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        logic [8*58-1:0] tab;
        tab = (alpha_sel == ALPHA_PLAIN) ? PLAIN_DIGITS : SWAPPED_DIGITS;
        return tab[8*(57-d) +: 8];
    endfunction

    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (digit_value(c, alpha_sel) >= 0)
        begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
        begin
            $display("ERROR: %s", msg);
        end
    endtask

    task automatic clear_text();
        store_len  = 0;
        lead_zeros = 0;
        in_lead    = 1'b1;
        dropping   = 1'b0;
    endtask

    task automatic flag_error(input logic [1:0] code, input logic last);
        out_word_t w;
        w.out_byte   = 8'h00;
        w.final_byte = 1'b1;
        w.status     = code;
        expected_bytes.push_back(w);
        if (last)
        begin
            clear_text();
        end
        else
        begin
            dropping = 1'b1;
        end
    endtask

    task automatic decode_char(input in_word_t c);
        out_word_t w;
        int d;
        int j;
        int carry;
        int n;
        if (dropping)
        begin
            if (c.end_of_string)
            begin
                clear_text();
            end
            return;
        end
        d = digit_value(c.text_char, alpha_sel);
        if (d < 0)
        begin
            flag_error(STATUS_BAD_CHAR, c.end_of_string);
            return;
        end
        if (in_lead && d == 0)
        begin
            if (lead_zeros + 1 > MAX_OUT_BYTES)
            begin
                flag_error(STATUS_OVERFLOW, c.end_of_string);
                return;
            end
            lead_zeros++;
        end
        else
        begin
            in_lead = 1'b0;
            carry   = d;
            for (j = 0; j < store_len; j++)
            begin
                carry          = carry + store_bytes[j] * 58;
                store_bytes[j] = carry[7:0];
                carry          = carry >> 8;
            end
            while (carry > 0)
            begin
                if (lead_zeros + store_len + 1 > MAX_OUT_BYTES || store_len >= MAX_OUT_BYTES)
                begin
                    flag_error(STATUS_OVERFLOW, c.end_of_string);
                    return;
                end
                store_bytes[store_len] = carry[7:0];
                store_len++;
                carry = carry >> 8;
            end
        end
        if (!c.end_of_string)
        begin
            return;
        end
        n = lead_zeros + store_len;
        for (j = 0; j < n; j++)
        begin
            w.out_byte   = (j < lead_zeros) ? 8'h00 : store_bytes[n - 1 - j];
            w.final_byte = (j == n - 1);
            w.status     = STATUS_OK;
            expected_bytes.push_back(w);
        end
        clear_text();
    endtask

    task automatic add_char(input logic [7:0] ch, input logic last);
        in_word_t c;
        c.text_char     = ch;
        c.end_of_string = last;
        pending_chars.push_back(c);
    endtask

    task automatic fill_random(input int count);
        int added;
        int kind;
        int lead;
        int body;
        int len;
        int bad_pos;
        int k;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                // well-formed string, sometimes with one bad character
                lead    = $urandom_range(3);
                body    = (lead > 0) ? $urandom_range(8) : $urandom_range(8, 1);
                len     = lead + body;
                bad_pos = (kind >= 65) ? $urandom_range(len - 1) : -1;
                for (k = 0; k < len; k++)
                begin
                    if (k == bad_pos)
                    begin
                        add_char(random_bad_char(), k == len - 1);
                    end
                    else if (k < lead)
                    begin
                        add_char(digit_char(0), k == len - 1);
                    end
                    else
                    begin
                        add_char(digit_char($urandom_range(57)), k == len - 1);
                    end
                end
            end
            else if (kind < 92)
            begin
                // raw bytes with random marks
                len = $urandom_range(5, 1);
                for (k = 0; k < len; k++)
                begin
                    add_char(8'($urandom_range(255)), (k == len - 1) ? 1'b1 : 1'($urandom_range(1)));
                end
            end
            else
            begin
                // long string near the store limit
                len = $urandom_range(45, 30);
                for (k = 0; k < len; k++)
                begin
                    add_char(digit_char($urandom_range(57, 1)), k == len - 1);
                end
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || char_valid || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_alphabet(input logic sel);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sel;
        @(posedge clk);
        cfg_we    <= 1'b0;
        alpha_sel = sel;
    endtask

    // character driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_word  <= '0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                decode_char(char_word);
                chars_in++;
            end
            if (char_valid && char_stall)
            begin
                char_valid <= 1'b1;
            end
            else if (pending_chars.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                char_valid <= 1'b1;
                char_word  <= pending_chars.pop_front();
            end
            else
            begin
                char_valid <= 1'b0;
            end
        end
    end

    // byte monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_stall <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                bytes_out++;
                if (byte_word.status != STATUS_OK)
                begin
                    error_words++;
                end
                if (expected_bytes.size() == 0)
                begin
                    report_error($sformatf("unexpected word %h", byte_word));
                end
                else
                begin
                    want_word = expected_bytes.pop_front();
                    if (byte_word.out_byte !== want_word.out_byte)
                    begin
                        report_error($sformatf("out_byte got %h expected %h",
                            byte_word.out_byte, want_word.out_byte));
                    end
                    if (byte_word.final_byte !== want_word.final_byte)
                    begin
                        report_error($sformatf("final_byte got %b expected %b",
                            byte_word.final_byte, want_word.final_byte));
                    end
                    if (byte_word.status !== want_word.status)
                    begin
                        report_error($sformatf("status got %0d expected %0d",
                            byte_word.status, want_word.status));
                    end
                end
            end
            byte_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (byte_valid && !byte_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int k;
        mismatch_count = 0;
        chars_in       = 0;
        bytes_out      = 0;
        error_words    = 0;
        quiet_cycles   = 0;
        alpha_sel      = ALPHA_PLAIN;
        clear_text();
        send_gap_pct   = 36;
        recv_gap_pct   = 61;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_alphabet(ALPHA_PLAIN);
        add_char("1", 1'b1);
        add_char("z", 1'b1);
        add_char("1", 1'b0);
        add_char("1", 1'b0);
        add_char("2", 1'b1);
        add_char("2", 1'b0);
        add_char("1", 1'b1);
        add_char(8'h00, 1'b1);
        add_char(8'hff, 1'b1);
        add_char("l", 1'b1);
        add_char("0", 1'b0);
        add_char("I", 1'b0);
        add_char("O", 1'b1);
        for (k = 0; k < 4; k++)
        begin
            add_char("z", k == 3);
        end
        add_char("A", 1'b1);
        fill_random(8);
        wait_drained();

        send_gap_pct = 61;
        recv_gap_pct = 36;
        write_alphabet(ALPHA_SWAPPED);
        add_char("a", 1'b1);
        add_char("Z", 1'b1);
        // zero run one past the store, error on the marked character
        for (k = 0; k < 33; k++)
        begin
            add_char(digit_char(0), k == 32);
        end
        // store filled to the top, the next digit overflows and the rest is dropped
        for (k = 0; k < 45; k++)
        begin
            add_char(digit_char(57), k == 44);
        end
        fill_random(6);
        wait_drained();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_alphabet(ALPHA_PLAIN);
        fill_random(10);
        wait_drained();

        $display("summary: %0d characters in, %0d bytes out, %0d error words", chars_in,
            bytes_out, error_words);
        $display("both digit orders, invalid characters, zero runs and store overflow covered");
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
